/* src/signed_restoring_divider_64_by_32_macros.svh */
// assertion macros shared by the divider checker
// no dependencies; include by bare file name
`ifndef SIGNED_RESTORING_DIVIDER_64_BY_32_MACROS_SVH
`define SIGNED_RESTORING_DIVIDER_64_BY_32_MACROS_SVH

// clocked property, held off while reset is low
`define SRDIV_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: divider property failed");

// clocked implication, held off while reset is low
`define SRDIV_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: divider implication failed");

`endif

/* src/srdiv_pkg.sv */
// shared widths, latency and the word carried along the divider cell chain
// no dependencies
package srdiv_pkg;

    localparam int DIVIDEND_W = 64;
    localparam int DIVISOR_W  = 32;
    // remainder magnitude stays below the divisor magnitude, at most 2^31 - 1
    localparam int REM_W      = DIVISOR_W - 1;
    localparam int STEPS      = DIVIDEND_W;
    // one operand stage, one cell per quotient bit, one sign stage
    localparam int LATENCY    = STEPS + 2;

    // partial state of one transaction as it moves down the chain
    typedef struct packed {
        logic [REM_W-1:0]      rem;
        logic [DIVIDEND_W-1:0] aq;
        logic [DIVISOR_W-1:0]  mag_d;
        logic                  neg_q;
        logic                  neg_r;
        logic                  zero;
    } srdiv_word_t;

endpackage

/* src/srdiv_prep.sv */
// operand stage: takes magnitudes and signs of a new transaction
// depends on srdiv_pkg
module srdiv_prep
    import srdiv_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic signed [DIVIDEND_W-1:0] dividend,
    input  logic signed [DIVISOR_W-1:0]  divisor,
    output logic                         out_valid,
    output srdiv_word_t                  out_word
);

    logic [DIVIDEND_W-1:0] a_u;
    logic [DIVISOR_W-1:0]  b_u;
    logic                  valid_reg;
    srdiv_word_t           word_reg;
    srdiv_word_t           word_next;

    assign a_u = dividend;
    assign b_u = divisor;

    // magnitudes; the most negative values keep their own bit pattern
    always_comb
    begin
        word_next.rem   = '0;
        word_next.aq    = a_u[DIVIDEND_W-1] ? (~a_u + DIVIDEND_W'(1)) : a_u;
        word_next.mag_d = b_u[DIVISOR_W-1] ? (~b_u + DIVISOR_W'(1)) : b_u;
        word_next.neg_q = a_u[DIVIDEND_W-1] ^ b_u[DIVISOR_W-1];
        word_next.neg_r = a_u[DIVIDEND_W-1];
        word_next.zero  = (b_u == '0);
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

/* src/srdiv_cell.sv */
// one restoring step: shift in a dividend bit, compare, subtract, emit a quotient bit
// depends on srdiv_pkg
module srdiv_cell
    import srdiv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  srdiv_word_t in_word,
    output logic        out_valid,
    output srdiv_word_t out_word
);

    logic [DIVISOR_W-1:0] trial;
    logic [DIVISOR_W:0]   diff;
    logic                 fits;
    logic                 valid_reg;
    srdiv_word_t          word_reg;
    srdiv_word_t          word_next;

    // partial remainder with the next dividend bit, tested against the divisor
    assign trial = {in_word.rem, in_word.aq[DIVIDEND_W-1]};
    assign diff  = {1'b0, trial} - {1'b0, in_word.mag_d};
    assign fits  = ~diff[DIVISOR_W];

    // restore or keep the difference; quotient bit enters at the bottom
    always_comb
    begin
        word_next     = in_word;
        word_next.rem = fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
        word_next.aq  = {in_word.aq[DIVIDEND_W-2:0], fits};
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

/* src/srdiv_fix.sv */
// result stage: applies signs, forces zero results for a zero divisor
// depends on srdiv_pkg
module srdiv_fix
    import srdiv_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  srdiv_word_t                  in_word,
    output logic                         done,
    output logic signed [DIVIDEND_W-1:0] quotient,
    output logic signed [DIVISOR_W-1:0]  remainder_out
);

    logic [DIVISOR_W-1:0]  rem_mag;
    logic [DIVIDEND_W-1:0] quotient_next;
    logic [DIVISOR_W-1:0]  remainder_next;
    logic                  done_reg;
    logic [DIVIDEND_W-1:0] quotient_reg;
    logic [DIVISOR_W-1:0]  remainder_reg;

    assign rem_mag = {1'b0, in_word.rem};

    // sign correction; a magnitude of 2^63 negates to the most negative value
    always_comb
    begin
        if (in_word.zero)
        begin
            quotient_next  = '0;
            remainder_next = '0;
        end
        else
        begin
            quotient_next  = in_word.neg_q ? (~in_word.aq + DIVIDEND_W'(1)) : in_word.aq;
            remainder_next = in_word.neg_r ? (~rem_mag + DIVISOR_W'(1)) : rem_mag;
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        quotient_reg  <= quotient_next;
        remainder_reg <= remainder_next;
    end

    assign done          = done_reg;
    assign quotient      = quotient_reg;
    assign remainder_out = remainder_reg;

endmodule

/* src/signed_restoring_divider_64_by_32.sv */
// an accepted start reaches done through the operand stage, 64 cells and the sign stage
// throughput: one transaction per cycle; busy stays low, the cell chain is fully pipelined
// every cell resolves one quotient bit with a 32-bit compare-subtract per cycle
// the receiver cannot stall: done marks each result for exactly one cycle
// reset (rst_n low, asynchronous) clears every valid flag; transactions in flight are dropped
// depends on srdiv_pkg, srdiv_prep, srdiv_cell, srdiv_fix
module signed_restoring_divider_64_by_32
    import srdiv_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [DIVIDEND_W-1:0] dividend,
    input  logic signed [DIVISOR_W-1:0]  divisor,
    output logic                         done,
    output logic signed [DIVIDEND_W-1:0] quotient,
    output logic signed [DIVISOR_W-1:0]  remainder_out
);

    logic [STEPS:0] chain_valid;
    srdiv_word_t    chain_word [STEPS+1];
    logic           accept;

    // new transaction every cycle
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // operand stage
    srdiv_prep u_prep
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .dividend  (dividend),
        .divisor   (divisor),
        .out_valid (chain_valid[0]),
        .out_word  (chain_word[0])
    );

    // one cell per quotient bit, most significant first
    for (genvar i = 0; i < STEPS; i++)
    begin : g_cell
        srdiv_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_word   (chain_word[i]),
            .out_valid (chain_valid[i+1]),
            .out_word  (chain_word[i+1])
        );
    end

    // sign stage
    srdiv_fix u_fix
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (chain_valid[STEPS]),
        .in_word       (chain_word[STEPS]),
        .done          (done),
        .quotient      (quotient),
        .remainder_out (remainder_out)
    );

endmodule

/* src/srdiv_checker.sv */
// port-level checks on the divider: timing of done, zero divisor, remainder sign
// depends on srdiv_pkg and signed_restoring_divider_64_by_32_macros.svh
`include "signed_restoring_divider_64_by_32_macros.svh"

module srdiv_checker
    import srdiv_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic [DIVIDEND_W-1:0] dividend,
    input logic [DIVISOR_W-1:0]  divisor,
    input logic                  done,
    input logic [DIVIDEND_W-1:0] quotient,
    input logic [DIVISOR_W-1:0]  remainder_out
);

    // each accepted transaction comes out after the fixed latency
    `SRDIV_ASSERT_IMPLY(a_done_follows, clk, rst_n, start && !busy, ##LATENCY done)

    // no result without a transaction accepted the fixed latency before
    `SRDIV_ASSERT_IMPLY(a_done_has_source, clk, rst_n, done,
        $past(start && !busy, LATENCY))

    // zero divisor gives zero quotient and remainder
    `SRDIV_ASSERT_IMPLY(a_zero_divisor, clk, rst_n, start && !busy && divisor == '0,
        ##LATENCY (quotient == '0 && remainder_out == '0))

    // a non-zero remainder carries the dividend's sign
    `SRDIV_ASSERT_IMPLY(a_rem_sign, clk, rst_n, done && remainder_out != '0,
        remainder_out[DIVISOR_W-1] == $past(dividend[DIVIDEND_W-1], LATENCY))

endmodule

bind signed_restoring_divider_64_by_32 srdiv_checker u_srdiv_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .dividend      (dividend),
    .divisor       (divisor),
    .done          (done),
    .quotient      (quotient),
    .remainder_out (remainder_out)
);

/* dv/tb_top.sv */
// self-checking testbench for signed_restoring_divider_64_by_32
// depends on srdiv_pkg and the divider rtl; a local quotient predictor checks every result
module tb_top;
    import srdiv_pkg::*;

    localparam logic signed [DIVIDEND_W-1:0] DVD_MIN = {1'b1, {(DIVIDEND_W-1){1'b0}}};
    localparam logic signed [DIVIDEND_W-1:0] DVD_MAX = {1'b0, {(DIVIDEND_W-1){1'b1}}};
    localparam logic signed [DIVISOR_W-1:0]  DVS_MIN = {1'b1, {(DIVISOR_W-1){1'b0}}};
    localparam logic signed [DIVISOR_W-1:0]  DVS_MAX = {1'b0, {(DIVISOR_W-1){1'b1}}};
    localparam int WATCHDOG_LIMIT = 30 * LATENCY;

    // expected quotient and remainder of one transaction
    typedef struct packed {
        logic [DIVIDEND_W-1:0] quo;
        logic [DIVISOR_W-1:0]  rem;
    } quotient_pair_t;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic signed [DIVIDEND_W-1:0] dividend;
    logic signed [DIVISOR_W-1:0]  divisor;
    logic                         done;
    logic signed [DIVIDEND_W-1:0] quotient;
    logic signed [DIVISOR_W-1:0]  remainder_out;

    quotient_pair_t pending_quotients[$];
    int             mismatch_count;
    int             sender_idle_pct;
    int             quiet_cycles;

    signed_restoring_divider_64_by_32 uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .dividend     (dividend),
        .divisor      (divisor),
        .done         (done),
        .quotient     (quotient),
        .remainder_out(remainder_out)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // restoring division on magnitudes, signs applied afterwards
    function automatic quotient_pair_t divide_signed(input logic signed [DIVIDEND_W-1:0] a,
                                                     input logic signed [DIVISOR_W-1:0] b);
        quotient_pair_t        res;
        logic [DIVIDEND_W-1:0] mag_a;
        logic [DIVISOR_W-1:0]  mag_b;
        logic [DIVIDEND_W-1:0] part;
        logic [DIVIDEND_W-1:0] quo_mag;
        logic [DIVIDEND_W-1:0] rem_full;
        mag_a   = a[DIVIDEND_W-1] ? -a : a;
        mag_b   = b[DIVISOR_W-1] ? -b : b;
        part    = '0;
        quo_mag = '0;
        res     = '0;
        if (mag_b == '0)
            return res;
        for (int i = DIVIDEND_W - 1; i >= 0; i--)
        begin
            part = {part[DIVIDEND_W-2:0], mag_a[i]};
            if (part >= {{(DIVIDEND_W-DIVISOR_W){1'b0}}, mag_b})
            begin
                part       = part - {{(DIVIDEND_W-DIVISOR_W){1'b0}}, mag_b};
                quo_mag[i] = 1'b1;
            end
        end
        // a magnitude of 2^63 negates to itself, giving the most negative value
        res.quo  = (a[DIVIDEND_W-1] ^ b[DIVISOR_W-1]) ? -quo_mag : quo_mag;
        rem_full = a[DIVIDEND_W-1] ? -part : part;
        res.rem  = rem_full[DIVISOR_W-1:0];
        return res;
    endfunction

    // one line per mismatch, counted
    task automatic report_mismatch(input string what, input logic [DIVIDEND_W-1:0] got,
                                   input logic [DIVIDEND_W-1:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // record accepted transactions and check each result against the oldest expectation
    always @(posedge clk)
    begin
        quotient_pair_t want;
        if (rst_n)
        begin
            if (start && !busy)
                pending_quotients.push_back(divide_signed(dividend, divisor));
            if (done)
            begin
                if (pending_quotients.size() == 0)
                    report_mismatch("unexpected result, quotient", quotient, '0);
                else
                begin
                    want = pending_quotients.pop_front();
                    if (quotient !== want.quo)
                        report_mismatch("quotient", quotient, want.quo);
                    if (remainder_out !== want.rem)
                        report_mismatch("remainder_out", {32'b0, remainder_out},
                                        {32'b0, want.rem});
                end
            end
        end
    end

    // watchdog on cycles with no transaction in either direction
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired at %0t", $time);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // one division request, with an optional random gap before it
    task automatic send_division(input logic signed [DIVIDEND_W-1:0] a,
                                 input logic signed [DIVISOR_W-1:0] b);
        int gap;
        if ($urandom_range(0, 99) < sender_idle_pct)
        begin
            gap = $urandom_range(1, 6);
            repeat (gap)
            begin
                @(negedge clk);
                start    <= 1'b0;
                dividend <= {$urandom, $urandom};
                divisor  <= $urandom;
            end
        end
        @(negedge clk);
        start    <= 1'b1;
        dividend <= a;
        divisor  <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // operand mixes that reach boundaries, small values and full-width noise
    function automatic logic signed [DIVIDEND_W-1:0] pick_dividend();
        logic signed [DIVIDEND_W-1:0] v;
        case ($urandom_range(0, 5))
            0: v = DVD_MIN;
            1: v = DVD_MAX;
            2: v = DIVIDEND_W'($urandom_range(0, 2000)) - 64'sd1000;
            3: v = $signed({$urandom, $urandom}) >>> $urandom_range(0, 62);
            4: v = ($urandom_range(0, 1) ? -64'sd1 : 64'sd1) <<< $urandom_range(0, 63);
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    function automatic logic signed [DIVISOR_W-1:0] pick_divisor();
        logic signed [DIVISOR_W-1:0] v;
        case ($urandom_range(0, 6))
            0: v = DVS_MIN;
            1: v = $urandom_range(0, 1) ? DVS_MAX : -32'sd1;
            2: v = $signed($urandom_range(0, 40)) - 20;
            3: v = $signed($urandom) >>> $urandom_range(0, 30);
            4: v = ($urandom_range(0, 1) ? -32'sd1 : 32'sd1) <<< $urandom_range(0, 31);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // extremes of both operands
    task automatic test_operand_extremes();
        send_division(DVD_MAX, 32'sd1);
        send_division(DVD_MAX, -32'sd1);
        send_division(DVD_MIN, 32'sd1);
        send_division(DVD_MAX, DVS_MIN);
        send_division(DVD_MAX, DVS_MAX);
        send_division(DVD_MIN, DVS_MAX);
        send_division(-64'sd1, DVS_MIN);
        send_division(64'sd1, DVS_MAX);
        send_division(64'sd0, -32'sd3);
    endtask

    // zero divisor gives zero quotient and remainder
    task automatic test_zero_divisor();
        send_division(64'sd0, 32'sd0);
        send_division(64'sd5, 32'sd0);
        send_division(DVD_MIN, 32'sd0);
        send_division(DVD_MAX, 32'sd0);
    endtask

    // DVD_MIN against several divisors; a quotient magnitude of 2^63 wraps to the most negative value
    task automatic test_quotient_wrap();
        send_division(DVD_MIN, -32'sd1);
        send_division(DVD_MIN, 32'sd2);
        send_division(DVD_MIN, DVS_MIN);
        send_division(DVD_MIN, -32'sd2);
    endtask

    // every sign combination, remainder follows the dividend
    task automatic test_sign_combinations();
        send_division(64'sd7, 32'sd2);
        send_division(-64'sd7, 32'sd2);
        send_division(64'sd7, -32'sd2);
        send_division(-64'sd7, -32'sd2);
        send_division(-64'sd1, -32'sd1);
        send_division(64'sd3, -32'sd5);
    endtask

    // random operands at a given sender idle rate
    task automatic test_random_operands(input int count, input int idle_pct);
        sender_idle_pct = idle_pct;
        repeat (count)
            send_division(pick_dividend(), pick_divisor());
    endtask

    // reset, test sequence and final verdict
    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        dividend        = '0;
        divisor         = '0;
        sender_idle_pct = 16;
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_operand_extremes();
        test_zero_divisor();
        test_quotient_wrap();
        test_sign_combinations();
        test_random_operands(143, 16);
        test_random_operands(143, 71);
        test_random_operands(144, 0);

        @(negedge clk);
        start <= 1'b0;
        // drain the pipeline, then watch for stray results
        while (pending_quotients.size() != 0)
            @(posedge clk);
        repeat (LATENCY)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* signed_restoring_divider_64_by_32.f */
+incdir+src
src/srdiv_pkg.sv
src/srdiv_prep.sv
src/srdiv_cell.sv
src/srdiv_fix.sv
src/signed_restoring_divider_64_by_32.sv
src/srdiv_checker.sv
dv/tb_top.sv
